@@ hdl/ltf_pkg.sv @@
// shared types and constants for the led twinkle fade engine
`default_nettype none

package ltf_pkg;

   localparam int LEVEL_W     = 8;
   localparam int INTERVAL_W  = 16;
   localparam int ELAPSED_W   = 17;
   localparam int LED_INDEX_W = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_MAX_LEVEL      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RISE_INTERVAL  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FALL_INTERVAL  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPAWN_INTERVAL = 2'd3;

   localparam logic [LEVEL_W-1:0]    MAX_LEVEL_RESET      = 8'd255;
   localparam logic [INTERVAL_W-1:0] RISE_INTERVAL_RESET  = 16'd1;
   localparam logic [INTERVAL_W-1:0] FALL_INTERVAL_RESET  = 16'd20;
   localparam logic [INTERVAL_W-1:0] SPAWN_INTERVAL_RESET = 16'd50;

   typedef logic [LEVEL_W-1:0] level_type;

   typedef struct packed {
      level_type level;
      logic      rising;
   } cell_state_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ hdl/ltf_cell.sv @@
// one led cell of the rotating state ring
`default_nettype none

module ltf_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  ltf_pkg::cell_ctrl_type ctrl,
   input  ltf_pkg::cell_state_type state_in,
   output ltf_pkg::cell_state_type state_out
);
   import ltf_pkg::*;

   cell_state_type state_ff;
   cell_state_type state_in_nxt;

   always_comb begin
      state_in_nxt = state_ff;
      if (ctrl.clear) begin
         state_in_nxt = '0;
      end else if (ctrl.shift) begin
         state_in_nxt = state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in_nxt;
      end
   end

   assign state_out = state_ff;

endmodule

`default_nettype wire

@@ hdl/ltf_timer.sv @@
// saturating interval timer that fires when its count exceeds the interval
`default_nettype none

module ltf_timer (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                tick,
   input  wire [ltf_pkg::INTERVAL_W-1:0]      interval,
   output logic                               fire
);
   import ltf_pkg::*;

   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

   logic [ELAPSED_W-1:0] elapsed_ff;
   logic [ELAPSED_W-1:0] elapsed_in;
   logic [ELAPSED_W-1:0] elapsed_inc;

   always_comb begin
      elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 1'b1;
      fire        = elapsed_inc > {1'b0, interval};
      elapsed_in  = elapsed_ff;
      if (tick) begin
         elapsed_in = fire ? '0 : elapsed_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
      end else begin
         elapsed_ff <= elapsed_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/led_twinkle_fade_engine.sv @@
// led twinkle fade engine top level: timers, rotating cell ring, result register
//
// each req_ transaction is one millisecond tick carrying req_random_index.
// on acceptance the spawn, rise and fall timers advance and their fire flags
// are captured; then, unless a held result is stalled, the ring of NUM_LEDS
// cells rotates one step per cycle, each led passing through the update logic at
// the ring head, so the tick produces NUM_LEDS rsp_ transactions in led order,
// rsp_last on the final. acceptance loads the run registers (busy, fire flags,
// pick); the first step then writes the first result into the output register.
// req_stall is high while a tick is being walked; the next tick is taken as
// soon as the last result is in the output register, even if not yet taken.
// rsp_stall, while a result is held, freezes the ring and the output register; nothing is lost.
// csr_ writes (csr_ready always high) set max_level and the three intervals;
// the user must make them only while the block is idle, which it does not enforce.
// reset (synchronous, active high) zeroes all levels, rising flags and timers
// and loads the register defaults; no clearing pass is needed.
`default_nettype none

module led_twinkle_fade_engine #(
   parameter int NUM_LEDS = 60
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [ltf_pkg::LED_INDEX_W-1:0]     req_random_index,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [ltf_pkg::LED_INDEX_W-1:0]     rsp_led_index,
   output logic [ltf_pkg::LEVEL_W-1:0]         rsp_level,
   output logic                                rsp_last,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [ltf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [ltf_pkg::CSR_DATA_W-1:0]      csr_data
);
   import ltf_pkg::*;

   localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LEDS - 1);

   // configuration registers
   level_type             max_level_ff;
   logic [INTERVAL_W-1:0] rise_interval_ff;
   logic [INTERVAL_W-1:0] fall_interval_ff;
   logic [INTERVAL_W-1:0] spawn_interval_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_level_ff      <= MAX_LEVEL_RESET;
         rise_interval_ff  <= RISE_INTERVAL_RESET;
         fall_interval_ff  <= FALL_INTERVAL_RESET;
         spawn_interval_ff <= SPAWN_INTERVAL_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MAX_LEVEL:      max_level_ff      <= csr_data[LEVEL_W-1:0];
            REG_RISE_INTERVAL:  rise_interval_ff  <= csr_data;
            REG_FALL_INTERVAL:  fall_interval_ff  <= csr_data;
            REG_SPAWN_INTERVAL: spawn_interval_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // timers
   logic req_accept;
   logic spawn_fire;
   logic rise_fire;
   logic fall_fire;

   assign req_accept = req_valid && !req_stall;

   ltf_timer u_spawn_timer (
      .clock    (clock),
      .reset    (reset),
      .tick     (req_accept),
      .interval (spawn_interval_ff),
      .fire     (spawn_fire)
   );

   ltf_timer u_rise_timer (
      .clock    (clock),
      .reset    (reset),
      .tick     (req_accept),
      .interval (rise_interval_ff),
      .fire     (rise_fire)
   );

   ltf_timer u_fall_timer (
      .clock    (clock),
      .reset    (reset),
      .tick     (req_accept),
      .interval (fall_interval_ff),
      .fire     (fall_fire)
   );

   // run control
   logic                   busy_ff, busy_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   spawn_ff, spawn_in;
   logic                   bright_ff, bright_in;
   logic                   dark_ff, dark_in;
   logic [LED_INDEX_W-1:0] pick_ff, pick_in;
   logic                   step;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LED_INDEX_W-1:0] rsp_led_index_ff, rsp_led_index_in;
   level_type              rsp_level_ff, rsp_level_in;
   logic                   rsp_last_ff, rsp_last_in;

   assign req_stall = busy_ff;
   assign step      = busy_ff && (!rsp_valid_ff || !rsp_stall);

   // cell ring, head at index zero, updated state enters at the tail
   cell_state_type ring_state [NUM_LEDS];
   cell_state_type upd_state;
   cell_ctrl_type  cell_ctrl;

   assign cell_ctrl.shift = step;
   assign cell_ctrl.clear = 1'b0;

   for (genvar k = 0; k < NUM_LEDS; k++) begin : g_cell
      if (k == NUM_LEDS - 1) begin : g_tail
         ltf_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (cell_ctrl),
            .state_in  (upd_state),
            .state_out (ring_state[k])
         );
      end else begin : g_body
         ltf_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (cell_ctrl),
            .state_in  (ring_state[k+1]),
            .state_out (ring_state[k])
         );
      end
   end

   // per-led update at the head of the ring
   always_comb begin
      upd_state        = ring_state[0];
      upd_state.rising = ring_state[0].rising ||
                         (spawn_ff && (pick_ff == LED_INDEX_W'(idx_ff)));
      if (bright_ff && upd_state.rising) begin
         if (upd_state.level >= max_level_ff) begin
            upd_state.rising = 1'b0;
         end else begin
            upd_state.level = upd_state.level + 1'b1;
         end
      end
      if (dark_ff && !upd_state.rising && (upd_state.level != '0)) begin
         upd_state.level = upd_state.level - 1'b1;
      end
   end

   always_comb begin
      busy_in          = busy_ff;
      idx_in           = idx_ff;
      spawn_in         = spawn_ff;
      bright_in        = bright_ff;
      dark_in          = dark_ff;
      pick_in          = pick_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_led_index_in = rsp_led_index_ff;
      rsp_level_in     = rsp_level_ff;
      rsp_last_in      = rsp_last_ff;
      if (req_accept) begin
         busy_in   = 1'b1;
         idx_in    = '0;
         spawn_in  = spawn_fire;
         bright_in = rise_fire;
         dark_in   = fall_fire;
         pick_in   = req_random_index;
      end
      if (step) begin
         rsp_valid_in     = 1'b1;
         rsp_led_index_in = LED_INDEX_W'(idx_ff);
         rsp_level_in     = upd_state.level;
         rsp_last_in      = (idx_ff == LAST_IDX);
         if (idx_ff == LAST_IDX) begin
            busy_in = 1'b0;
            idx_in  = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      spawn_ff         <= spawn_in;
      bright_ff        <= bright_in;
      dark_ff          <= dark_in;
      pick_ff          <= pick_in;
      rsp_led_index_ff <= rsp_led_index_in;
      rsp_level_ff     <= rsp_level_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_led_index = rsp_led_index_ff;
   assign rsp_level     = rsp_level_ff;
   assign rsp_last      = rsp_last_ff;

   // checks
   a_accept_starts_run: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (busy_ff && (idx_ff == '0)))
      else $error("tick accepted but run did not start at led zero");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= LAST_IDX))
      else $error("led counter beyond last led");

   a_last_on_final_led: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_led_index == LED_INDEX_W'(NUM_LEDS - 1)))
      else $error("last flag on a led other than the final one");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (step && (idx_ff == LAST_IDX)) |=> (rsp_valid && rsp_last))
      else $error("final led step did not present last result");

endmodule

`default_nettype wire
